// ===== sv/mbo_pkg.sv =====
// ----------------------------------------------------------------------------
// mbo_pkg
// Shared types and constants of the moving box overlap interval core.
// ----------------------------------------------------------------------------
package mbo_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_START = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_END   = 1'b1;

    // Status of the shared divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/mbo_item_if.sv =====
// ----------------------------------------------------------------------------
// mbo_item_if
// Input channel: one dimension of both boxes, edges and edge velocities.
// ----------------------------------------------------------------------------
interface mbo_item_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_low;
    logic signed [COORD_WIDTH-1:0] a_high;
    logic signed [COORD_WIDTH-1:0] a_low_speed;
    logic signed [COORD_WIDTH-1:0] a_high_speed;
    logic signed [COORD_WIDTH-1:0] b_low;
    logic signed [COORD_WIDTH-1:0] b_high;
    logic signed [COORD_WIDTH-1:0] b_low_speed;
    logic signed [COORD_WIDTH-1:0] b_high_speed;
    logic                          last_dim;

    modport source (
        output valid, a_low, a_high, a_low_speed, a_high_speed,
               b_low, b_high, b_low_speed, b_high_speed, last_dim,
        input  ready
    );

    modport sink (
        input  valid, a_low, a_high, a_low_speed, a_high_speed,
               b_low, b_high, b_low_speed, b_high_speed, last_dim,
        output ready
    );
endinterface

// ===== sv/mbo_result_if.sv =====
// ----------------------------------------------------------------------------
// mbo_result_if
// Output channel: overlap flag and overlap interval of one box pair.
// ----------------------------------------------------------------------------
interface mbo_result_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          overlaps;
    logic signed [COORD_WIDTH-1:0] overlap_begin;
    logic signed [COORD_WIDTH-1:0] overlap_end;

    modport source (
        output valid, overlaps, overlap_begin, overlap_end,
        input  ready
    );

    modport sink (
        input  valid, overlaps, overlap_begin, overlap_end,
        output ready
    );
endinterface

// ===== sv/mbo_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mbo_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mbo_cfg_if #(
    parameter int COORD_WIDTH = 32
);
    logic                                 valid;
    logic                                 ready;
    logic [mbo_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [COORD_WIDTH-1:0]               data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== sv/moving_box_overlap_interval_core.sv =====
// ----------------------------------------------------------------------------
// moving_box_overlap_interval_core
// Overlap test of two moving boxes in a time window, one dimension per beat;
// the overlap interval of the pair comes out on the beat marked last_dim.
//
//   channel  dir  handshake         payload
//   item     in   valid / ready     edges, edge speeds, last_dim
//   result   out  valid / ready     overlaps, overlap_begin, overlap_end
//   cfg      in   valid / ready     index, data (window_start, window_end)
//
// An item of an already rejected pair skips the arithmetic. Otherwise the eight
// projections go through one multiplier, then classify and merge, and a pair
// rejected at classification skips the merge; each crossing time, at most two,
// is computed on the shared radix-2 divider. item.ready is high only while idle.
// A finished result waits in the output register; the next item is taken
// meanwhile and only a further last_dim beat holds until result is free. Reset
// clears the window registers and the pair state; cfg is always ready.
// ----------------------------------------------------------------------------
module moving_box_overlap_interval_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    mbo_item_if.sink     item,
    mbo_result_if.source result,
    mbo_cfg_if.sink      cfg
);
    import mbo_pkg::*;

    localparam int W         = COORD_WIDTH;
    localparam int NUM_WIDTH = COORD_WIDTH + FRAC_BITS + 1;
    localparam int DEN_WIDTH = COORD_WIDTH + 1;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};
    localparam logic [NUM_WIDTH-1:0] HALF = {{(NUM_WIDTH - W){1'b0}}, 1'b1,
                                             {(W - 1){1'b0}}};

    localparam logic [3:0] PROJ_LAST = 4'd8;

    // Projection slots: low two bits pick the edge, bit 2 picks window end
    localparam int AL_S = 0;
    localparam int AH_S = 1;
    localparam int BL_S = 2;
    localparam int BH_S = 3;
    localparam int AL_E = 4;
    localparam int AH_E = 5;
    localparam int BL_E = 6;
    localparam int BH_E = 7;

    localparam int EA_LOW  = 0;
    localparam int EA_HIGH = 1;
    localparam int EB_LOW  = 2;
    localparam int EB_HIGH = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROJ,
        ST_CLASSIFY,
        ST_DIV_A,
        ST_DIV_B,
        ST_MERGE,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [3:0]          cnt_reg;
    logic                div_start_reg;
    logic                sel_above_reg;
    logic signed [W-1:0] ts_reg;
    logic signed [W-1:0] te_reg;
    logic signed [W-1:0] run_begin_reg;
    logic signed [W-1:0] run_end_reg;
    logic                rejected_reg;
    logic                first_dim_reg;
    logic signed [W-1:0] t_above_reg;
    logic signed [W-1:0] t_below_reg;
    logic                out_valid_reg;
    logic                out_overlaps_reg;
    logic signed [W-1:0] out_begin_reg;
    logic signed [W-1:0] out_end_reg;

    logic signed [W-1:0] edge_reg  [4];
    logic signed [W-1:0] speed_reg [4];
    logic signed [W-1:0] proj_reg  [8];
    logic                last_reg;

    logic                mul_issue;
    logic signed [W-1:0] mul_proj;
    logic [2:0]          cap_idx;

    logic above_s, below_s, above_e, below_e;
    logic reject_now, need_above, need_below;

    logic signed [W:0]      num_wide;
    logic signed [W:0]      den_wide;
    logic                   num_neg;
    logic                   den_neg;
    logic                   num_zero;
    logic                   den_zero;
    logic [W:0]             num_mag;
    logic [W:0]             den_mag;
    logic [NUM_WIDTH-1:0]   div_numer;
    logic [NUM_WIDTH-1:0]   div_quot;
    div_stat_t              div_stat;
    logic signed [W-1:0]    q_sat;
    logic signed [W:0]      t_sum;
    logic signed [W-1:0]    t_calc;

    logic signed [W-1:0] cb;
    logic signed [W-1:0] ce;
    logic                out_free;
    logic                out_load;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= '0;
            te_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WINDOW_START: ts_reg <= cfg.data;
                REG_WINDOW_END:   te_reg <= cfg.data;
            endcase
        end
    end

    // ---------------------------------------------------------- item capture
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            edge_reg[EA_LOW]   <= item.a_low;
            edge_reg[EA_HIGH]  <= item.a_high;
            edge_reg[EB_LOW]   <= item.b_low;
            edge_reg[EB_HIGH]  <= item.b_high;
            speed_reg[EA_LOW]  <= item.a_low_speed;
            speed_reg[EA_HIGH] <= item.a_high_speed;
            speed_reg[EB_LOW]  <= item.b_low_speed;
            speed_reg[EB_HIGH] <= item.b_high_speed;
            last_reg           <= item.last_dim;
        end
        if (state_reg == ST_PROJ && cnt_reg != 4'd0)
            proj_reg[cap_idx] <= mul_proj;
    end

    // ------------------------------------------------------------ projection
    assign mul_issue = (state_reg == ST_PROJ) && (cnt_reg != PROJ_LAST);
    assign cap_idx   = 3'(cnt_reg - 4'd1);

    mbo_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mul (
        .clk      (clk),
        .issue    (mul_issue),
        .edge_pos (edge_reg[cnt_reg[1:0]]),
        .speed    (speed_reg[cnt_reg[1:0]]),
        .at_time  (cnt_reg[2] ? te_reg : ts_reg),
        .proj     (mul_proj)
    );

    // -------------------------------------------------------- classification
    always_comb
    begin
        above_s    = proj_reg[BH_S] < proj_reg[AL_S];
        below_s    = proj_reg[AH_S] < proj_reg[BL_S];
        above_e    = proj_reg[BH_E] < proj_reg[AL_E];
        below_e    = proj_reg[AH_E] < proj_reg[BL_E];
        reject_now = (above_s && above_e) || (below_s && below_e);
        need_above = above_s || above_e;
        need_below = below_s || below_e;
    end

    // ------------------------------------------------------- crossing times
    always_comb
    begin
        if (sel_above_reg)
        begin
            num_wide = {proj_reg[BH_S][W-1], proj_reg[BH_S]}
                     - {proj_reg[AL_S][W-1], proj_reg[AL_S]};
            den_wide = {speed_reg[EA_LOW][W-1], speed_reg[EA_LOW]}
                     - {speed_reg[EB_HIGH][W-1], speed_reg[EB_HIGH]};
        end
        else
        begin
            num_wide = {proj_reg[BL_S][W-1], proj_reg[BL_S]}
                     - {proj_reg[AH_S][W-1], proj_reg[AH_S]};
            den_wide = {speed_reg[EA_HIGH][W-1], speed_reg[EA_HIGH]}
                     - {speed_reg[EB_LOW][W-1], speed_reg[EB_LOW]};
        end
        num_neg   = num_wide[W];
        den_neg   = den_wide[W];
        num_zero  = (num_wide == '0);
        den_zero  = (den_wide == '0);
        num_mag   = num_neg ? (~num_wide + 1'b1) : num_wide;
        den_mag   = den_neg ? (~den_wide + 1'b1) : den_wide;
        div_numer = NUM_WIDTH'(num_mag) << FRAC_BITS;

        // Sign, saturation and zero-divisor rules on the raw magnitude
        priority if (den_zero)
            q_sat = num_zero ? '0 : (num_neg ? MINV : MAXV);
        else if (num_neg == den_neg)
            q_sat = (div_quot >= HALF) ? MAXV : div_quot[W-1:0];
        else
            q_sat = (div_quot > HALF) ? MINV : (~div_quot[W-1:0] + 1'b1);

        t_sum = {ts_reg[W-1], ts_reg} + {q_sat[W-1], q_sat};
        if (t_sum[W] != t_sum[W-1])
            t_calc = t_sum[W] ? MINV : MAXV;
        else
            t_calc = t_sum[W-1:0];
    end

    mbo_div #(
        .NUM_WIDTH (NUM_WIDTH),
        .DEN_WIDTH (DEN_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .numer    (div_numer),
        .denom    (den_mag),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // ----------------------------------------------------------------- merge
    always_comb
    begin
        cb = above_s ? t_above_reg : (below_s ? t_below_reg : ts_reg);
        ce = above_e ? t_above_reg : (below_e ? t_below_reg : te_reg);
    end

    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (state_reg == ST_FINISH) && last_reg && out_free;

    // ------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            div_start_reg    <= 1'b0;
            sel_above_reg    <= 1'b0;
            run_begin_reg    <= '0;
            run_end_reg      <= '0;
            rejected_reg     <= 1'b0;
            first_dim_reg    <= 1'b1;
            t_above_reg      <= '0;
            t_below_reg      <= '0;
            out_valid_reg    <= 1'b0;
            out_overlaps_reg <= 1'b0;
            out_begin_reg    <= '0;
            out_end_reg      <= '0;
        end
        else
        begin
            div_start_reg <= (state_reg == ST_CLASSIFY && !reject_now
                              && (need_above || need_below))
                          || (state_reg == ST_DIV_A && div_stat.done && need_below);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        cnt_reg   <= '0;
                        // skip the arithmetic for a pair already rejected
                        state_reg <= rejected_reg ? ST_FINISH : ST_PROJ;
                    end
                end

                ST_PROJ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == PROJ_LAST)
                        state_reg <= ST_CLASSIFY;
                end

                ST_CLASSIFY:
                begin
                    priority if (reject_now)
                    begin
                        rejected_reg <= 1'b1;
                        state_reg    <= ST_FINISH;
                    end
                    else if (need_above)
                    begin
                        sel_above_reg <= 1'b1;
                        state_reg     <= ST_DIV_A;
                    end
                    else if (need_below)
                    begin
                        sel_above_reg <= 1'b0;
                        state_reg     <= ST_DIV_B;
                    end
                    else
                        state_reg <= ST_MERGE;
                end

                ST_DIV_A:
                begin
                    if (div_stat.done)
                    begin
                        t_above_reg <= t_calc;
                        if (need_below)
                        begin
                            sel_above_reg <= 1'b0;
                            state_reg     <= ST_DIV_B;
                        end
                        else
                            state_reg <= ST_MERGE;
                    end
                end

                ST_DIV_B:
                begin
                    if (div_stat.done)
                    begin
                        t_below_reg <= t_calc;
                        state_reg   <= ST_MERGE;
                    end
                end

                ST_MERGE:
                begin
                    priority if (first_dim_reg)
                    begin
                        run_begin_reg <= cb;
                        run_end_reg   <= ce;
                    end
                    else if (run_end_reg < cb || ce < run_begin_reg)
                        rejected_reg <= 1'b1;
                    else
                    begin
                        if (run_begin_reg < cb)
                            run_begin_reg <= cb;
                        if (ce < run_end_reg)
                            run_end_reg <= ce;
                    end
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (!last_reg)
                    begin
                        first_dim_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_overlaps_reg <= !rejected_reg;
                        out_begin_reg    <= rejected_reg ? '0 : run_begin_reg;
                        out_end_reg      <= rejected_reg ? '0 : run_end_reg;
                        // return the pair state to its reset values
                        run_begin_reg    <= '0;
                        run_end_reg      <= '0;
                        rejected_reg     <= 1'b0;
                        first_dim_reg    <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign item.ready           = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.overlaps      = out_overlaps_reg;
    assign result.overlap_begin = out_begin_reg;
    assign result.overlap_end   = out_end_reg;

    // ------------------------------------------------------------ assertions
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("item accepted while previous item still in work");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside pair completion");

    a_pair_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> first_dim_reg && !rejected_reg)
        else $error("pair state not cleared after result");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.overlaps |->
            result.overlap_begin == '0 && result.overlap_end == '0)
        else $error("rejected pair carries a nonzero interval");

endmodule

// ===== sv/mbo_mul.sv =====
// ----------------------------------------------------------------------------
// mbo_mul
// Shared projection unit: registered v * t, then x + (v * t >>> FRAC_BITS)
// saturated to COORD_WIDTH bits. The result follows in the cycle after issue.
// ----------------------------------------------------------------------------
module mbo_mul #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 12
) (
    input  logic                          clk,
    input  logic                          issue,
    input  logic signed [COORD_WIDTH-1:0] edge_pos,
    input  logic signed [COORD_WIDTH-1:0] speed,
    input  logic signed [COORD_WIDTH-1:0] at_time,
    output logic signed [COORD_WIDTH-1:0] proj
);
    localparam int PW = 2 * COORD_WIDTH;

    localparam logic signed [PW:0] SUM_MAX = {{(COORD_WIDTH + 2){1'b0}},
                                              {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [PW:0] SUM_MIN = {{(COORD_WIDTH + 2){1'b1}},
                                              {(COORD_WIDTH - 1){1'b0}}};

    logic signed [PW-1:0]          prod_reg;
    logic signed [COORD_WIDTH-1:0] pos_reg;
    logic signed [PW-1:0]          prod_sh;
    logic signed [PW:0]            sum;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= speed * at_time;
            pos_reg  <= edge_pos;
        end
    end

    always_comb
    begin
        prod_sh = prod_reg >>> FRAC_BITS;
        sum     = {{(COORD_WIDTH + 1){pos_reg[COORD_WIDTH-1]}}, pos_reg}
                + {prod_sh[PW-1], prod_sh};
        priority if (sum > SUM_MAX)
            proj = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
        else if (sum < SUM_MIN)
            proj = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
        else
            proj = sum[COORD_WIDTH-1:0];
    end

endmodule

// ===== sv/mbo_div.sv =====
// ----------------------------------------------------------------------------
// mbo_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// Operands load on start; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module mbo_div #(
    parameter int NUM_WIDTH = 45,
    parameter int DEN_WIDTH = 33
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUM_WIDTH-1:0]   numer,
    input  logic [DEN_WIDTH-1:0]   denom,
    output mbo_pkg::div_stat_t     stat,
    output logic [NUM_WIDTH-1:0]   quotient
);
    import mbo_pkg::*;

    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

    logic [DEN_WIDTH-1:0] rem_reg;
    logic [NUM_WIDTH-1:0] quo_reg;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DEN_WIDTH:0]   trial;
    logic [DEN_WIDTH+1:0] diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_WIDTH-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        fits  = ~diff[DEN_WIDTH+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_WIDTH'(1));
            if (start)
            begin
                cnt_reg  <= CNT_WIDTH'(NUM_WIDTH);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_WIDTH'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Numerator shifts out of quo_reg as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= numer;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
            quo_reg <= {quo_reg[NUM_WIDTH-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== test/moving_box_overlap_interval_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_box_overlap_interval_monitor
// Watches the item, result and cfg channels of the overlap core, predicts
// the overlap interval of every box pair and compares each result beat
// against the oldest prediction. Hands a failure count and the number of
// outstanding predictions back to the testbench top.
// ----------------------------------------------------------------------------
module moving_box_overlap_interval_monitor #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 12
) (
    input  logic   clk,
    input  logic   rst_n,
    mbo_item_if    item,
    mbo_result_if  result,
    mbo_cfg_if     cfg,
    output int     fail_count,
    output int     pending
);
    import mbo_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic                   overlaps;
        logic [COORD_WIDTH-1:0] enter_time;
        logic [COORD_WIDTH-1:0] exit_time;
    } overlap_t;

    localparam wide_t MAX_C = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam wide_t MIN_C = -(wide_t'(1) <<< (COORD_WIDTH - 1));

    logic [COORD_WIDTH-1:0] win_start;
    logic [COORD_WIDTH-1:0] win_end;
    wide_t                  run_begin;
    wide_t                  run_end;
    logic                   pair_rejected;
    logic                   first_dim;
    overlap_t               overlap_queue[$];

    function automatic wide_t widen(input logic [COORD_WIDTH-1:0] raw);
        return wide_t'($signed(raw));
    endfunction

    function automatic wide_t clamp(input wide_t v);
        if (v < MIN_C)
            return MIN_C;
        if (v > MAX_C)
            return MAX_C;
        return v;
    endfunction

    // Edge position at time t: floor of the scaled product, then saturate
    function automatic wide_t project(input wide_t x, input wide_t v, input wide_t t);
        return clamp(x + ((v * t) >>> FRAC_BITS));
    endfunction

    // Time to close a gap num at relative speed den, truncated toward zero
    function automatic wide_t crossing(input wide_t num, input wide_t den);
        if (den == 0)
        begin
            if (num == 0)
                return 0;
            return (num < 0) ? MIN_C : MAX_C;
        end
        return clamp((num <<< FRAC_BITS) / den);
    endfunction

    task automatic clear_pair();
        run_begin     = 0;
        run_end       = 0;
        pair_rejected = 1'b0;
        first_dim     = 1'b1;
    endtask

    task automatic fold_dimension();
        wide_t ts, te, al, ah, alv, ahv, bl, bh, blv, bhv;
        wide_t al_s, ah_s, bl_s, bh_s, al_e, ah_e, bl_e, bh_e;
        wide_t t_above, t_below, cb, ce;
        logic  above_s, below_s, above_e, below_e;
        if (pair_rejected)
            return;
        ts  = widen(win_start);
        te  = widen(win_end);
        al  = widen(item.a_low);
        ah  = widen(item.a_high);
        alv = widen(item.a_low_speed);
        ahv = widen(item.a_high_speed);
        bl  = widen(item.b_low);
        bh  = widen(item.b_high);
        blv = widen(item.b_low_speed);
        bhv = widen(item.b_high_speed);
        al_s = project(al, alv, ts);
        ah_s = project(ah, ahv, ts);
        bl_s = project(bl, blv, ts);
        bh_s = project(bh, bhv, ts);
        al_e = project(al, alv, te);
        ah_e = project(ah, ahv, te);
        bl_e = project(bl, blv, te);
        bh_e = project(bh, bhv, te);
        above_s = bh_s < al_s;
        below_s = ah_s < bl_s;
        above_e = bh_e < al_e;
        below_e = ah_e < bl_e;
        // Separated on the same side over the whole window
        if ((above_s && above_e) || (below_s && below_e))
        begin
            pair_rejected = 1'b1;
            return;
        end
        t_above = ts;
        t_below = ts;
        if (above_s || above_e)
            t_above = clamp(ts + crossing(bh_s - al_s, alv - bhv));
        if (below_s || below_e)
            t_below = clamp(ts + crossing(bl_s - ah_s, ahv - blv));
        cb = above_s ? t_above : (below_s ? t_below : ts);
        ce = above_e ? t_above : (below_e ? t_below : te);
        if (first_dim)
        begin
            run_begin = cb;
            run_end   = ce;
        end
        else if (run_end < cb || ce < run_begin)
        begin
            pair_rejected = 1'b1;
        end
        else
        begin
            if (run_begin < cb)
                run_begin = cb;
            if (ce < run_end)
                run_end = ce;
        end
    endtask

    task automatic check_overlap();
        overlap_t want;
        if (overlap_queue.size() == 0)
        begin
            $display("%0t: result beat with nothing outstanding: overlaps %0b, begin %0d, end %0d",
                     $time, result.overlaps, result.overlap_begin, result.overlap_end);
            fail_count++;
            return;
        end
        want = overlap_queue.pop_front();
        if (result.overlaps !== want.overlaps)
        begin
            $display("%0t: overlaps expected %0b, actual %0b",
                     $time, want.overlaps, result.overlaps);
            fail_count++;
        end
        if (result.overlap_begin !== want.enter_time)
        begin
            $display("%0t: overlap_begin expected %0d, actual %0d",
                     $time, $signed(want.enter_time), result.overlap_begin);
            fail_count++;
        end
        if (result.overlap_end !== want.exit_time)
        begin
            $display("%0t: overlap_end expected %0d, actual %0d",
                     $time, $signed(want.exit_time), result.overlap_end);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start  = '0;
            win_end    = '0;
            fail_count = 0;
            overlap_queue.delete();
            clear_pair();
        end
        else
        begin
            // Retire first so a result never matches a beat taken at this edge
            if (result.valid && result.ready)
                check_overlap();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_WINDOW_START)
                    win_start = cfg.data;
                else if (cfg.index == REG_WINDOW_END)
                    win_end = cfg.data;
            end
            if (item.valid && item.ready)
            begin
                fold_dimension();
                first_dim = 1'b0;
                if (item.last_dim)
                begin
                    overlap_queue.push_back(pair_rejected ? overlap_t'(0) :
                        {1'b1, run_begin[COORD_WIDTH-1:0], run_end[COORD_WIDTH-1:0]});
                    clear_pair();
                end
            end
        end
        pending = overlap_queue.size();
    end

endmodule

// ===== test/moving_box_overlap_interval_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_box_overlap_interval_core_tb
// Drives box pairs one dimension per beat into the overlap core: a directed
// set of corner cases, then random pairs under a series of time windows,
// with bursty input pacing and an output stall pattern. The monitor checks
// every result; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module moving_box_overlap_interval_core_tb;
    import mbo_pkg::*;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 12;
    localparam int ONE           = 1 << FRAC_BITS;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 150;
    localparam int NUM_PHASES    = 10;
    localparam int RANDOM_ITEMS  = 1750;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t a_low;
        coord_t a_high;
        coord_t a_low_speed;
        coord_t a_high_speed;
        coord_t b_low;
        coord_t b_high;
        coord_t b_low_speed;
        coord_t b_high_speed;
    } dim_t;

    localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   burst_left;

    mbo_item_if   #(.COORD_WIDTH(COORD_WIDTH)) item ();
    mbo_result_if #(.COORD_WIDTH(COORD_WIDTH)) result ();
    mbo_cfg_if    #(.COORD_WIDTH(COORD_WIDTH)) cfg ();

    moving_box_overlap_interval_core #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    moving_box_overlap_interval_monitor #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) overlap_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        item.valid        = 1'b0;
        item.a_low        = '0;
        item.a_high       = '0;
        item.a_low_speed  = '0;
        item.a_high_speed = '0;
        item.b_low        = '0;
        item.b_high       = '0;
        item.b_low_speed  = '0;
        item.b_high_speed = '0;
        item.last_dim     = 1'b0;
        result.ready      = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = REG_WINDOW_START;
        cfg.data          = '0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: long ready stretches, random stalls and mostly-stalled runs
    initial
    begin
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       result.ready <= 1'b1;
                    1:       result.ready <= $urandom_range(0, 1);
                    default: result.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic dim_t mk_dim(input coord_t al, input coord_t ah, input coord_t alv,
                                    input coord_t ahv, input coord_t bl, input coord_t bh,
                                    input coord_t blv, input coord_t bhv);
        return {al, ah, alv, ahv, bl, bh, blv, bhv};
    endfunction

    // Two proper boxes near each other, drifting at modest speeds
    function automatic dim_t near_dim();
        int ca, cb, wa, wb, va, vb;
        ca = spread(40 * ONE);
        cb = ca + spread(48 * ONE);
        wa = $urandom_range(0, 16 * ONE);
        wb = $urandom_range(0, 16 * ONE);
        va = spread(6 * ONE);
        vb = spread(6 * ONE);
        if ($urandom_range(0, 4) == 0)
            return mk_dim(ca - wa, ca + wa, va, va, cb - wb, cb + wb, vb, vb);
        return mk_dim(ca - wa, ca + wa, va + spread(ONE), va + spread(ONE),
                      cb - wb, cb + wb, vb + spread(ONE), vb + spread(ONE));
    endfunction

    function automatic coord_t pick_extreme();
        case ($urandom_range(0, 6))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            5:       return $urandom;
            default: return spread(8 * ONE);
        endcase
    endfunction

    function automatic dim_t extreme_dim();
        return mk_dim(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    endfunction

    function automatic dim_t noise_dim();
        return mk_dim($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic send_beat(input dim_t d, input logic last);
        @(negedge clk);
        item.valid        <= 1'b1;
        item.a_low        <= d.a_low;
        item.a_high       <= d.a_high;
        item.a_low_speed  <= d.a_low_speed;
        item.a_high_speed <= d.a_high_speed;
        item.b_low        <= d.b_low;
        item.b_high       <= d.b_high;
        item.b_low_speed  <= d.b_low_speed;
        item.b_high_speed <= d.b_high_speed;
        item.last_dim     <= last;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    // Burst pacing: hold valid high through a burst, then drop it for a gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
        @(negedge clk);
        item.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 12);
    endtask

    task automatic drain(input bit settle);
        @(negedge clk);
        item.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_INDEX_WIDTH-1:0] idx, input coord_t value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic directed_pairs();
        dim_t from_above, from_below, drifts_off;
        from_above = mk_dim(6 * ONE, 8 * ONE, -ONE, -ONE, 0, 2 * ONE, 0, 0);
        from_below = mk_dim(0, 2 * ONE, ONE, ONE, 5 * ONE, 6 * ONE, 0, 0);
        drifts_off = mk_dim(0, 2 * ONE, 0, 0, ONE, 3 * ONE, ONE, ONE);
        // touching edges, all zero
        send_beat(mk_dim(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
        // A above B all window long; the second dimension is ignored
        send_beat(mk_dim(10 * ONE, 12 * ONE, 0, 0, 0, 2 * ONE, 0, 0), 1'b0);
        send_beat(mk_dim(0, ONE, 0, 0, 0, ONE, 0, 0), 1'b1);
        // A below B all window long
        send_beat(mk_dim(0, ONE, 0, 0, 5 * ONE, 6 * ONE, 0, 0), 1'b1);
        send_beat(from_above, 1'b1);
        send_beat(from_below, 1'b1);
        send_beat(drifts_off, 1'b1);
        // intervals of the two dimensions do not meet
        send_beat(from_above, 1'b0);
        send_beat(drifts_off, 1'b1);
        // running interval shrinks over three dimensions
        send_beat(from_below, 1'b0);
        send_beat(mk_dim(0, 4 * ONE, 0, 0, ONE, 2 * ONE, 0, 0), 1'b0);
        send_beat(from_above, 1'b1);
        // saturated projections give equal speeds across a crossing
        send_beat(mk_dim(C_MAX, C_MAX, ONE, ONE, 0, C_MAX - 1, 0, ONE), 1'b1);
        send_beat(mk_dim(C_MIN, C_MIN, -ONE, -ONE, C_MIN + 1, 0, -ONE, 0), 1'b1);
        send_beat(mk_dim(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b1);
        send_beat(mk_dim(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b1);
        send_beat(mk_dim(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN), 1'b1);
        send_beat(mk_dim(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX), 1'b1);
        send_beat(mk_dim(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                         32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555), 1'b0);
        send_beat(mk_dim(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                         32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA), 1'b1);
    endtask

    task automatic random_pairs(input int count);
        int   sent;
        int   kind;
        int   dims;
        dim_t beat;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) == 0)
                drain(1'b0);
            kind = $urandom_range(0, 19);
            dims = $urandom_range(1, 3);
            for (int d = 0; d < dims; d++)
            begin
                if (kind < 14)
                    beat = near_dim();
                else if (kind < 17)
                    beat = extreme_dim();
                else
                    beat = noise_dim();
                send_beat(beat, d == dims - 1);
                pace_sender();
            end
            sent += dims;
        end
    endtask

    initial
    begin
        coord_t ws;
        coord_t we;
        cycle_count = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_window(REG_WINDOW_START, 0);
        write_window(REG_WINDOW_END, 8 * ONE);
        directed_pairs();
        drain(1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin ws = 0;         we = 0;         end
                1:       begin ws = -4 * ONE;  we = 12 * ONE;  end
                2:       begin ws = 2 * ONE;   we = 3 * ONE;   end
                3:       begin ws = 12 * ONE;  we = 2 * ONE;   end
                4:       begin ws = C_MIN;     we = C_MAX;     end
                5:       begin ws = C_MAX;     we = C_MIN;     end
                6:       begin ws = C_MAX;     we = C_MAX;     end
                7:       begin ws = C_MIN;     we = C_MIN;     end
                8:       begin ws = $urandom;  we = $urandom;  end
                default:
                begin
                    ws = spread(8 * ONE);
                    we = ws + $urandom_range(0, 32 * ONE);
                end
            endcase
            write_window(REG_WINDOW_START, ws);
            write_window(REG_WINDOW_END, we);
            random_pairs(RANDOM_ITEMS / NUM_PHASES);
            drain(1'b1);
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
